// ===== rtl/core/cmf_pkg.sv =====
// shared constants and types of the cross minimum filter
package cmf_pkg;

    localparam int MAX_WIDTH     = 2048;
    localparam int CHANNEL_BITS  = 8;
    localparam int PIX_BITS      = 3 * CHANNEL_BITS;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int FW_BITS       = 12;
    localparam int FH_BITS       = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic [COL_BITS-1:0] WIDTH_LAST_RST = COL_BITS'(639);
    localparam logic [FH_BITS-1:0]  HEIGHT_LAST_RST = FH_BITS'(479);

    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = QPTR_BITS + 1;

    typedef struct packed {
        logic [PIX_BITS-1:0] pix;
        logic                last_row;
        logic                last_col;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_qhead;

    typedef enum logic [1:0] {
        PH_PIX,
        PH_LROW,
        PH_LCOL,
        PH_CORNER
    } t_phase;

endpackage

// ===== rtl/core/cmf_pix_if.sv =====
// input pixel channel
interface cmf_pix_if import cmf_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] in_red;
    logic [CHANNEL_BITS-1:0] in_green;
    logic [CHANNEL_BITS-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

// ===== rtl/core/cmf_res_if.sv =====
// filtered result channel
interface cmf_res_if import cmf_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] out_red;
    logic [CHANNEL_BITS-1:0] out_green;
    logic [CHANNEL_BITS-1:0] out_blue;
    logic                    run_end;
    logic                    frame_end;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output run_end, output frame_end, input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  input run_end, input frame_end, output ready);
endinterface

// ===== rtl/core/cross_min_filter_rgb.sv =====
// top level of the rgb plus-shaped minimum filter
//
// Pixels enter in raster order on i_pix, results leave on o_res, both as
// valid/ready transfers. The frame size is set through the write port
// (index 0 frame width, index 1 frame height); any such write restarts the
// frame at its first pixel. Write only while the block is idle.
// The result for pixel (y,x) is produced by the input at (y+1,x+1) and
// reaches o_res through the r_s1 registers and the queue. The left
// border result of each row comes first and the right one follows the
// interior ones; the all-zero last row comes out interleaved with the final
// input row; run_end marks the last result of an input and frame_end the
// final pixel of the frame. Throughput is one pixel per cycle while the
// queue has room, set by the single read port per line store; in the last
// row each input gives two or more results, so the output port limits the rate.
// Reset clears position and window state and sets a 640 by 480 frame; the
// line stores are not cleared and need no clearing pass. i_pix.ready is low
// while reset is held. When the receiver stalls, a four-entry queue keeps
// taking work; i_pix.ready falls once the queue plus the entry in flight
// would fill it.
module cross_min_filter_rgb import cmf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    cmf_pix_if.sink                  i_pix,
    cmf_res_if.source                o_res
);

    t_push                push;
    t_qhead               head;
    logic                 pop;
    logic [QCNT_BITS-1:0] q_count;

    cmf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_q_count  (q_count),
        .o_push     (push)
    );

    cmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (q_count)
    );

    cmf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// ===== rtl/core/cmf_ram.sv =====
// generic single write port ram with registered read
module cmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/cmf_front.sv =====
// front end: position counters, line stores, window and cross minimum
module cmf_front import cmf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    cmf_pix_if.sink                  i_pix,
    input  logic [QCNT_BITS-1:0]     i_q_count,
    output t_push                    o_push
);

    function automatic logic [CHANNEL_BITS-1:0] min5(
        input logic [CHANNEL_BITS-1:0] a,
        input logic [CHANNEL_BITS-1:0] b,
        input logic [CHANNEL_BITS-1:0] d,
        input logic [CHANNEL_BITS-1:0] e,
        input logic [CHANNEL_BITS-1:0] f
    );
        logic [CHANNEL_BITS-1:0] m;
        m = a;
        if (b < m) m = b;
        if (d < m) m = d;
        if (e < m) m = e;
        if (f < m) m = f;
        return m;
    endfunction

    logic [COL_BITS-1:0] r_w_last;
    logic [FH_BITS-1:0]  r_h_last;
    logic [COL_BITS-1:0] r_col;
    logic [FH_BITS-1:0]  r_row;

    logic                r_s1_valid;
    logic [PIX_BITS-1:0] r_s1_pix;
    logic [COL_BITS-1:0] r_s1_col;
    logic                r_s1_emit;
    logic                r_s1_border;
    logic                r_s1_lr;
    logic                r_s1_lc;

    logic [PIX_BITS-1:0] r_mid_left;
    logic [PIX_BITS-1:0] r_mid_center;
    logic [PIX_BITS-1:0] r_top_center;
    logic [PIX_BITS-1:0] r_prev_pix;

    logic [COL_BITS-1:0]  col;
    logic [FH_BITS-1:0]   row;
    logic                 accept;
    logic                 cfg_hit;
    logic [QCNT_BITS:0]   occ;
    logic [FW_BITS-1:0]   cfg_fw;
    logic [FH_BITS-1:0]   cfg_fh;
    logic [PIX_BITS-1:0]  in_pix;
    logic [PIX_BITS-1:0]  right_pix;
    logic [PIX_BITS-1:0]  up_pix;
    logic [PIX_BITS-1:0]  min_pix;

    assign col     = (r_col > r_w_last) ? '0 : r_col;
    assign row     = (r_row > r_h_last) ? '0 : r_row;
    assign occ     = {1'b0, i_q_count} + {{QCNT_BITS{1'b0}}, r_s1_valid};
    assign i_pix.ready = i_rst_n && (occ < (QCNT_BITS + 1)'(QDEPTH));
    assign accept  = i_pix.valid && i_pix.ready;
    assign cfg_hit = i_cfg_we &&
                     (i_cfg_idx == REG_FRAME_WIDTH || i_cfg_idx == REG_FRAME_HEIGHT);
    assign cfg_fw  = i_cfg_data[FW_BITS-1:0];
    assign cfg_fh  = i_cfg_data[FH_BITS-1:0];
    assign in_pix  = {i_pix.in_blue, i_pix.in_green, i_pix.in_red};

    // frame size, kept as last column and last row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= WIDTH_LAST_RST;
            r_h_last <= HEIGHT_LAST_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_FRAME_WIDTH) begin
                if (cfg_fw < FW_BITS'(3)) begin
                    r_w_last <= COL_BITS'(2);
                end else if (int'(cfg_fw) > MAX_WIDTH) begin
                    r_w_last <= COL_BITS'(MAX_WIDTH - 1);
                end else begin
                    r_w_last <= COL_BITS'(cfg_fw - FW_BITS'(1));
                end
            end
            if (i_cfg_idx == REG_FRAME_HEIGHT) begin
                if (cfg_fh < FH_BITS'(3)) begin
                    r_h_last <= FH_BITS'(2);
                end else begin
                    r_h_last <= cfg_fh - FH_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col == r_w_last) begin
                r_col <= '0;
                r_row <= (row == r_h_last) ? '0 : row + FH_BITS'(1);
            end else begin
                r_col <= col + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix    <= in_pix;
            r_s1_col    <= col;
            r_s1_emit   <= (row != '0) && (col != '0);
            r_s1_border <= (row == FH_BITS'(1)) || (col == COL_BITS'(1));
            r_s1_lr     <= row == r_h_last;
            r_s1_lc     <= col == r_w_last;
        end
    end

    cmf_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_pix),
        .i_raddr (col),
        .o_rdata (right_pix)
    );

    cmf_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (right_pix),
        .i_raddr (col),
        .o_rdata (up_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_left   <= '0;
            r_mid_center <= '0;
            r_top_center <= '0;
            r_prev_pix   <= '0;
        end else if (r_s1_valid) begin
            r_mid_left   <= r_mid_center;
            r_mid_center <= right_pix;
            r_top_center <= up_pix;
            r_prev_pix   <= r_s1_pix;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            min_pix[k*CHANNEL_BITS +: CHANNEL_BITS] = min5(
                r_mid_center[k*CHANNEL_BITS +: CHANNEL_BITS],
                right_pix[k*CHANNEL_BITS +: CHANNEL_BITS],
                r_mid_left[k*CHANNEL_BITS +: CHANNEL_BITS],
                r_prev_pix[k*CHANNEL_BITS +: CHANNEL_BITS],
                r_top_center[k*CHANNEL_BITS +: CHANNEL_BITS]);
        end
    end

    assign o_push.valid          = r_s1_valid && r_s1_emit;
    assign o_push.entry.pix      = r_s1_border ? '0 : min_pix;
    assign o_push.entry.last_row = r_s1_lr;
    assign o_push.entry.last_col = r_s1_lc;

endmodule

// ===== rtl/core/cmf_queue.sv =====
// small queue between front and back end
module cmf_queue import cmf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_push                i_push,
    input  logic                 i_pop,
    output t_qhead               o_head,
    output logic [QCNT_BITS-1:0] o_count
);

    t_entry                r_mem [QDEPTH];
    logic [QPTR_BITS-1:0]  r_wp;
    logic [QPTR_BITS-1:0]  r_rp;
    logic [QCNT_BITS-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wp <= r_wp + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_BITS'(1);
            end
            r_count <= r_count + QCNT_BITS'(i_push.valid) - QCNT_BITS'(i_pop);
        end
    end

    assign o_head.valid = r_count != '0;
    assign o_head.entry = r_mem[r_rp];
    assign o_count      = r_count;

endmodule

// ===== rtl/core/cmf_back.sv =====
// back end: expands each queued entry into its result transfers
module cmf_back import cmf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_qhead     i_head,
    output logic       o_pop,
    cmf_res_if.source  o_res
);

    t_phase r_phase;
    t_phase n_phase;
    t_phase step;
    logic   done;
    logic   xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PIX;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        step = PH_PIX;
        done = 1'b0;
        unique case (r_phase)
            PH_PIX: begin
                if (i_head.entry.last_row) begin
                    step = PH_LROW;
                end else if (i_head.entry.last_col) begin
                    step = PH_LCOL;
                end else begin
                    done = 1'b1;
                end
            end
            PH_LROW: begin
                if (i_head.entry.last_col) begin
                    step = PH_LCOL;
                end else begin
                    done = 1'b1;
                end
            end
            PH_LCOL: begin
                if (i_head.entry.last_row) begin
                    step = PH_CORNER;
                end else begin
                    done = 1'b1;
                end
            end
            PH_CORNER: begin
                done = 1'b1;
            end
        endcase

        xfer    = i_head.valid && o_res.ready;
        o_pop   = xfer && done;
        n_phase = r_phase;
        if (xfer) begin
            n_phase = done ? PH_PIX : step;
        end
    end

    assign o_res.valid     = i_head.valid;
    assign o_res.out_red   = (r_phase == PH_PIX) ?
                             i_head.entry.pix[0 +: CHANNEL_BITS] : '0;
    assign o_res.out_green = (r_phase == PH_PIX) ?
                             i_head.entry.pix[CHANNEL_BITS +: CHANNEL_BITS] : '0;
    assign o_res.out_blue  = (r_phase == PH_PIX) ?
                             i_head.entry.pix[2*CHANNEL_BITS +: CHANNEL_BITS] : '0;
    assign o_res.run_end   = done;
    assign o_res.frame_end = r_phase == PH_CORNER;

endmodule

// ===== rtl/core/cmf_chk.sv =====
// port-level checker of the filter, bound to the top level
module cmf_chk import cmf_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    i_ready,
    input logic [CHANNEL_BITS-1:0] i_red,
    input logic [CHANNEL_BITS-1:0] i_green,
    input logic [CHANNEL_BITS-1:0] i_blue,
    input logic                    i_run_end,
    input logic                    i_frame_end
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_red) && $stable(i_green) &&
                                 $stable(i_blue) && $stable(i_run_end) &&
                                 $stable(i_frame_end))
        else $error("result changed while stalled");

    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_frame_end |-> i_run_end)
        else $error("frame end not on last result of its input");

    a_frame_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_frame_end |-> i_red == '0 && i_green == '0 && i_blue == '0)
        else $error("final pixel of frame not zero");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result offered right after reset");

endmodule

bind cross_min_filter_rgb cmf_chk u_cmf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_res.valid),
    .i_ready     (o_res.ready),
    .i_red       (o_res.out_red),
    .i_green     (o_res.out_green),
    .i_blue      (o_res.out_blue),
    .i_run_end   (o_res.run_end),
    .i_frame_end (o_res.frame_end)
);
